// ===== src/lap3_pkg.sv =====
// shared constants, types and helper functions for the six-neighbour 3d laplacian
`timescale 1ns / 1ps

package lap3_pkg;

	localparam int MAX_X       = 256;
	localparam int MAX_Y       = 256;
	localparam int MAX_Z       = 256;
	localparam int SAMPLE_BITS = 16;

	// fixed field widths of the ports
	localparam int IN_W      = 16;
	localparam int LAP_W     = 20;
	localparam int CFG_W     = 9;
	localparam int CFG_IDX_W = 2;

	localparam int XW  = $clog2(MAX_X);
	localparam int YW  = $clog2(MAX_Y);
	localparam int ZW  = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;
	localparam int XHW = (XW > 1) ? XW - 1 : 1;
	localparam int YHW = (YW > 1) ? YW - 1 : 1;

	// one bank holds both plane slots for one (row parity, column parity) pair
	localparam int ADDR_W     = 1 + YHW + XHW;
	localparam int BANK_DEPTH = 2 ** ADDR_W;
	localparam int N_BANKS    = 4;

	// largest magnitude of a result
	localparam int LAP_MAX = 6 * ((2 ** SAMPLE_BITS) - 1);

	localparam logic [CFG_W-1:0] DIM_RESET = 9'd256;

	localparam logic [CFG_IDX_W-1:0] REG_DIM_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIM_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DIM_Z = 2'd2;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_DRAIN  = 1'b1;

	typedef logic [SAMPLE_BITS-1:0] smp_t;

	typedef struct packed {
		logic [XW-1:0] x;
		logic [YW-1:0] y;
		logic [ZW-1:0] z;
	} pos_t;

	typedef struct packed {
		pos_t pos;
		logic wrap;
	} adv_t;

	typedef struct packed {
		logic          en;
		logic [XW-1:0] x;
		logic [YW-1:0] y;
		logic          slot;
	} rd_req_t;

	typedef struct packed {
		logic          we;
		logic [XW-1:0] x;
		logic [YW-1:0] y;
		logic          slot;
		smp_t          data;
	} wr_req_t;

	typedef struct packed {
		smp_t centre;
		smp_t below;
		smp_t xm;
		smp_t xp;
		smp_t ym;
		smp_t yp;
	} nbr_t;

	typedef struct packed {
		logic has_below;
		logic has_up;
		logic has_ym;
		logic has_yp;
		logic has_xm;
		logic has_xp;
	} nbr_flags_t;

	// last valid index for a dimension register: zero acts as one, clamp to maxv
	function automatic int unsigned eff_last(input logic [CFG_W-1:0] v,
			input int unsigned maxv);
		int unsigned e;
		if (v == '0)
			e = 1;
		else if (32'(v) > maxv)
			e = maxv;
		else
			e = 32'(v);
		return e - 1;
	endfunction

	// raster step, x fastest; wrap is set when stepping past the last plane
	function automatic adv_t pos_advance(input pos_t p, input pos_t l);
		adv_t r;
		r.pos  = p;
		r.wrap = 1'b0;
		if (p.x != l.x) begin
			r.pos.x = p.x + 1'b1;
		end else begin
			r.pos.x = '0;
			if (p.y != l.y) begin
				r.pos.y = p.y + 1'b1;
			end else begin
				r.pos.y = '0;
				if (p.z != l.z) begin
					r.pos.z = p.z + 1'b1;
				end else begin
					r.pos.z = '0;
					r.wrap  = 1'b1;
				end
			end
		end
		return r;
	endfunction

endpackage

// ===== src/lap3_window.sv =====
// two-plane sample window in four parity banks, six neighbour reads per clock while rd.en is set
`timescale 1ns / 1ps

module lap3_window import lap3_pkg::*; (
	input  logic    clk,
	input  rd_req_t rd,
	input  wr_req_t wr,
	output nbr_t    nbr
);

	logic [XW-1:0] xm, xp;
	logic [YW-1:0] ym, yp;
	logic [XHW-1:0] xh, xmh, xph, wxh;
	logic [YHW-1:0] yh, ymh, yph, wyh;
	logic q, p;
	logic [1:0] wbank;
	logic [ADDR_W-1:0] waddr;

	smp_t rd0_s1 [N_BANKS];
	smp_t rd1_s1 [N_BANKS];
	logic q_s1, p_s1;

	// x-1 and x+1 share a column parity, as do y-1 and y+1
	assign q  = rd.y[0];
	assign p  = rd.x[0];
	assign xm = rd.x - 1'b1;
	assign xp = rd.x + 1'b1;
	assign ym = rd.y - 1'b1;
	assign yp = rd.y + 1'b1;

	assign xh  = XHW'(rd.x >> 1);
	assign xmh = XHW'(xm >> 1);
	assign xph = XHW'(xp >> 1);
	assign yh  = YHW'(rd.y >> 1);
	assign ymh = YHW'(ym >> 1);
	assign yph = YHW'(yp >> 1);

	assign wxh   = XHW'(wr.x >> 1);
	assign wyh   = YHW'(wr.y >> 1);
	assign wbank = {wr.y[0], wr.x[0]};
	assign waddr = {wr.slot, wyh, wxh};

	for (genvar b = 0; b < N_BANKS; b++) begin : g_bank
		localparam logic [1:0] BID = 2'(b);

		smp_t mem [BANK_DEPTH];
		logic [ADDR_W-1:0] ra0, ra1;

		always_comb begin
			if (BID[1] == q && BID[0] == p) begin
				// centre plane and the plane below, same spot
				ra0 = {rd.slot, yh, xh};
				ra1 = {~rd.slot, yh, xh};
			end else if (BID[1] == q) begin
				ra0 = {rd.slot, yh, xmh};
				ra1 = {rd.slot, yh, xph};
			end else begin
				ra0 = {rd.slot, ymh, xh};
				ra1 = {rd.slot, yph, xh};
			end
		end

		// read returns the old word when the write hits the same address
		always_ff @(posedge clk) begin
			if (wr.we && wbank == BID)
				mem[waddr] <= wr.data;
			if (rd.en) begin
				rd0_s1[b] <= mem[ra0];
				rd1_s1[b] <= mem[ra1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			q_s1 <= q;
			p_s1 <= p;
		end
	end

	assign nbr.centre = rd0_s1[{q_s1, p_s1}];
	assign nbr.below  = rd1_s1[{q_s1, p_s1}];
	assign nbr.xm     = rd0_s1[{q_s1, ~p_s1}];
	assign nbr.xp     = rd1_s1[{q_s1, ~p_s1}];
	assign nbr.ym     = rd0_s1[{~q_s1, p_s1}];
	assign nbr.yp     = rd1_s1[{~q_s1, p_s1}];

endmodule

// ===== src/laplacian_3d_six_neighbour.sv =====
// streaming six-neighbour 3d laplacian over a two-plane window
// path: accepted item, s1 window read register, s2 result register, out_valid
// throughput: one item per clock unless in_stall; the four window banks each take two
// reads and a write every clock, so nothing in the path iterates
// reset: asynchronous, clears positions, done flag and pipeline valids, dims go to 256;
// window contents are not cleared
`timescale 1ns / 1ps

module laplacian_3d_six_neighbour import lap3_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    operation,
	input  logic [IN_W-1:0]         sample,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [LAP_W-1:0] laplacian,
	output logic                    last,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]        cfg_data
);

	pos_t dim_last_q;
	pos_t in_q, out_q;
	logic done_q;

	adv_t adv_in, adv_out;
	logic accept, take_sample, take_drain, emit, out_last;
	smp_t smp;

	rd_req_t rd;
	wr_req_t wr;
	nbr_t    nbr;

	logic       valid_s1;
	nbr_flags_t flags_s1;
	smp_t       up_s1;
	logic       last_s1;

	logic                    valid_s2;
	logic signed [LAP_W-1:0] lap_s2;
	logic                    last_s2;

	logic             s1_move;
	logic [2:0]       cnt;
	logic [LAP_W-1:0] nsum, prod, lap_d;

	assign smp         = sample[SAMPLE_BITS-1:0];
	assign s1_move     = !valid_s2 || !out_stall;
	assign in_stall    = valid_s1 && !s1_move;
	assign accept      = in_valid && !in_stall;
	assign take_sample = accept && operation == OP_SAMPLE && !done_q;
	assign take_drain  = accept && operation == OP_DRAIN && done_q;
	// once past the first plane every sample finishes the voxel one plane back
	assign emit        = (take_sample && in_q.z != '0) || take_drain;
	assign out_last    = out_q == dim_last_q;
	assign adv_in      = pos_advance(in_q, dim_last_q);
	assign adv_out     = pos_advance(out_q, dim_last_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_last_q.x <= XW'(eff_last(DIM_RESET, MAX_X));
			dim_last_q.y <= YW'(eff_last(DIM_RESET, MAX_Y));
			dim_last_q.z <= ZW'(eff_last(DIM_RESET, MAX_Z));
			in_q         <= '0;
			out_q        <= '0;
			done_q       <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DIM_X: begin
					dim_last_q.x <= XW'(eff_last(cfg_data, MAX_X));
					in_q         <= '0;
					out_q        <= '0;
					done_q       <= 1'b0;
				end
				REG_DIM_Y: begin
					dim_last_q.y <= YW'(eff_last(cfg_data, MAX_Y));
					in_q         <= '0;
					out_q        <= '0;
					done_q       <= 1'b0;
				end
				REG_DIM_Z: begin
					dim_last_q.z <= ZW'(eff_last(cfg_data, MAX_Z));
					in_q         <= '0;
					out_q        <= '0;
					done_q       <= 1'b0;
				end
				default: begin
					done_q <= done_q;
				end
			endcase
		end else begin
			if (take_sample) begin
				in_q <= adv_in.pos;
				if (adv_in.wrap)
					done_q <= 1'b1;
				if (in_q.z != '0)
					out_q <= adv_out.pos;
			end
			if (take_drain) begin
				if (out_last) begin
					out_q  <= '0;
					done_q <= 1'b0;
				end else begin
					out_q <= adv_out.pos;
				end
			end
		end
	end

	assign rd.en   = emit;
	assign rd.x    = out_q.x;
	assign rd.y    = out_q.y;
	assign rd.slot = out_q.z[0];

	assign wr.we   = take_sample;
	assign wr.x    = in_q.x;
	assign wr.y    = in_q.y;
	assign wr.slot = in_q.z[0];
	assign wr.data = smp;

	lap3_window u_window (
		.clk (clk),
		.rd  (rd),
		.wr  (wr),
		.nbr (nbr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!in_stall)
				valid_s1 <= emit;
			if (s1_move)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			flags_s1.has_below <= out_q.z != '0;
			flags_s1.has_up    <= operation == OP_SAMPLE;
			flags_s1.has_ym    <= out_q.y != '0;
			flags_s1.has_yp    <= out_q.y != dim_last_q.y;
			flags_s1.has_xm    <= out_q.x != '0;
			flags_s1.has_xp    <= out_q.x != dim_last_q.x;
			up_s1              <= smp;
			last_s1            <= take_drain && out_last;
		end
	end

	// neighbours that lie outside the volume drop out of both sum and count
	always_comb begin
		nsum = LAP_W'(flags_s1.has_below ? nbr.below : '0)
			+ LAP_W'(flags_s1.has_up ? up_s1 : '0)
			+ LAP_W'(flags_s1.has_ym ? nbr.ym : '0)
			+ LAP_W'(flags_s1.has_yp ? nbr.yp : '0)
			+ LAP_W'(flags_s1.has_xm ? nbr.xm : '0)
			+ LAP_W'(flags_s1.has_xp ? nbr.xp : '0);
		cnt   = 3'($countones(flags_s1));
		prod  = LAP_W'(cnt) * LAP_W'(nbr.centre);
		lap_d = nsum - prod;
	end

	always_ff @(posedge clk) begin
		if (s1_move && valid_s1) begin
			lap_s2  <= lap_d;
			last_s2 <= last_s1;
		end
	end

	assign out_valid = valid_s2;
	assign laplacian = lap_s2;
	assign last      = last_s2;

endmodule

// ===== src/lap3_checker.sv =====
// port-level checks for the laplacian block, bound to the top level
`timescale 1ns / 1ps

module lap3_checker import lap3_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_stall,
	input logic                    out_valid,
	input logic                    out_stall,
	input logic signed [LAP_W-1:0] laplacian,
	input logic                    last
);

	// input only backs up when a finished word is waiting downstream
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with no blocked output word");

	// every new word comes from an accepted item, looking back across the s1 and s2 registers
	a_word_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("output word without an accepted item");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(laplacian) && $stable(last))
		else $error("stalled output word changed");

endmodule

bind laplacian_3d_six_neighbour lap3_checker u_lap3_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.laplacian (laplacian),
	.last      (last)
);
